// ----- rtl/itp_pkg.sv -----
// Shared types and constants of the idle throttle target and PID block.
package itp_pkg;

   // Fixed PID gains, unsigned Q2.8.
   localparam logic [9:0] INTEGRAL_GAIN_Q8   = 10'd26;
   localparam logic [9:0] DERIVATIVE_GAIN_Q8 = 10'd64;

   // Second operand width of the shared multiplier (a 16-bit value plus a sign bit).
   localparam int MUL_B_W = 17;
   // Split point of the PID sum for the two-pass gain multiplication.
   localparam int LO_W    = 24;
   // Width of the low partial product (LO_W bits times the 16-bit gain).
   localparam int LOWP_W  = LO_W + 16;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_CRANKING_RPM     = 3'd0,
      REG_POST_START_START = 3'd1,
      REG_POST_START_STEP  = 3'd2,
      REG_SLOPE_GRADIENT   = 3'd3,
      REG_SLOPE_OFFSET     = 3'd4,
      REG_IDLE_NORMAL      = 3'd5,
      REG_IDLE_FAST        = 3'd6,
      REG_LOOP_GAIN        = 3'd7
   } itp_reg_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [13:0]        cranking_rpm;
      logic [9:0]         post_start_start;
      logic [15:0]        post_start_step;
      logic signed [15:0] slope_gradient;
      logic signed [15:0] slope_offset;
      logic [9:0]         idle_normal;
      logic [9:0]         idle_fast;
      logic [15:0]        loop_gain;
   } itp_cfg_type;

   // Step commands from the sequencer to the datapath.
   typedef struct packed {
      logic load;
      logic slope_mul;
      logic clamp;
      logic target;
      logic error;
      logic integ_mul;
      logic deriv_mul;
      logic accum;
      logic low_mul;
      logic high_mul;
      logic finish;
   } itp_cmd_type;

endpackage

// ----- rtl/itp_if.sv -----
// Handshake channel interfaces for input words and result words.
interface itp_req_if;
   logic               valid;
   logic               ready;
   logic [9:0]         throttle_position;
   logic signed [11:0] engine_temp;
   logic [13:0]        engine_rpm;
   logic signed [10:0] target_adjust;

   modport source (output valid, output throttle_position, output engine_temp,
                   output engine_rpm, output target_adjust, input ready);
   modport sink   (input valid, input throttle_position, input engine_temp,
                   input engine_rpm, input target_adjust, output ready);
endinterface

interface itp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [11:0] target_throttle;
   logic signed [23:0] actuator_demand;

   modport source (output valid, output target_throttle, output actuator_demand,
                   input ready);
   modport sink   (input valid, input target_throttle, input actuator_demand,
                   output ready);
endinterface

// ----- rtl/idle_throttle_target_and_pid.sv -----
// Idle throttle target with post-start schedule and PID stage: top level.
//
// Each input word (req_chan) is one control tick: measured throttle, engine
// temperature, engine speed and a host trim. Each tick yields exactly one
// result word (rsp_chan): the chosen target throttle and the saturated,
// gain-scaled PID demand. Both channels use a valid/ready handshake.
// The block works on one word at a time. A word is taken when the sequencer
// is idle; the sequencer then steps it through slope, clamp, target, error,
// integral, derivative, accumulate, low and high product and finish, and
// takes no new word before finish. These steps come from the use of the single
// shared 17-bit by (at least) 25-bit multiplier: slope, integral term,
// derivative term and the two halves of the loop gain product.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds in its last step until the register is free.
// Configuration is written through the APB-style port, register i at byte
// address 4*i, and should only change while the block is idle.
// Synchronous reset returns the registers to their defaults and clears the
// post-start level, the error sum and the previous error.
module idle_throttle_target_and_pid
   import itp_pkg::*;
#(
   parameter int SUM_WIDTH = 24
)
(
   input  logic        clock,
   input  logic        reset,
   itp_req_if.sink     req_chan,
   itp_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   itp_cfg_type cfg;
   itp_cmd_type cmd;

   assign pready = 1'b1;

   // Configuration registers.
   itp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // Sequencer.
   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Arithmetic.
   itp_datapath #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .cfg                  (cfg),
      .in_throttle_position (req_chan.throttle_position),
      .in_engine_temp       (req_chan.engine_temp),
      .in_engine_rpm        (req_chan.engine_rpm),
      .in_target_adjust     (req_chan.target_adjust),
      .out_target_throttle  (rsp_chan.target_throttle),
      .out_actuator_demand  (rsp_chan.actuator_demand)
   );

endmodule

// ----- rtl/itp_csr.sv -----
// Configuration register file behind the APB-style port.
module itp_csr
   import itp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output itp_cfg_type cfg
);

   itp_cfg_type cfg_ff;
   itp_cfg_type cfg_in;
   itp_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel = itp_reg_type'(paddr[4:2]);
   assign wr_en   = psel && penable && pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_CRANKING_RPM:     cfg_in.cranking_rpm     = pwdata[13:0];
            REG_POST_START_START: cfg_in.post_start_start = pwdata[9:0];
            REG_POST_START_STEP:  cfg_in.post_start_step  = pwdata[15:0];
            REG_SLOPE_GRADIENT:   cfg_in.slope_gradient   = $signed(pwdata[15:0]);
            REG_SLOPE_OFFSET:     cfg_in.slope_offset     = $signed(pwdata[15:0]);
            REG_IDLE_NORMAL:      cfg_in.idle_normal      = pwdata[9:0];
            REG_IDLE_FAST:        cfg_in.idle_fast        = pwdata[9:0];
            REG_LOOP_GAIN:        cfg_in.loop_gain        = pwdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cranking_rpm     <= 14'd400;
         cfg_ff.post_start_start <= '0;
         cfg_ff.post_start_step  <= 16'd256;
         cfg_ff.slope_gradient   <= '0;
         cfg_ff.slope_offset     <= '0;
         cfg_ff.idle_normal      <= '0;
         cfg_ff.idle_fast        <= '0;
         cfg_ff.loop_gain        <= 16'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_sel)
         REG_CRANKING_RPM:     prdata = {18'd0, cfg_ff.cranking_rpm};
         REG_POST_START_START: prdata = {22'd0, cfg_ff.post_start_start};
         REG_POST_START_STEP:  prdata = {16'd0, cfg_ff.post_start_step};
         REG_SLOPE_GRADIENT:   prdata = {16'd0, cfg_ff.slope_gradient};
         REG_SLOPE_OFFSET:     prdata = {16'd0, cfg_ff.slope_offset};
         REG_IDLE_NORMAL:      prdata = {22'd0, cfg_ff.idle_normal};
         REG_IDLE_FAST:        prdata = {22'd0, cfg_ff.idle_fast};
         REG_LOOP_GAIN:        prdata = {16'd0, cfg_ff.loop_gain};
         default:              prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/itp_ctrl.sv -----
// Sequencer that steps one word at a time through the datapath.
module itp_ctrl
   import itp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output itp_cmd_type cmd
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_SLOPE  = 11'b000_0000_0010,
      ST_CLAMP  = 11'b000_0000_0100,
      ST_TARGET = 11'b000_0000_1000,
      ST_ERROR  = 11'b000_0001_0000,
      ST_INTEG  = 11'b000_0010_0000,
      ST_DERIV  = 11'b000_0100_0000,
      ST_ACCUM  = 11'b000_1000_0000,
      ST_LOW    = 11'b001_0000_0000,
      ST_HIGH   = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   // The result register may be refilled once it is empty or being taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            cmd.slope_mul = 1'b1;
            state_in      = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_TARGET;
         end
         ST_TARGET: begin
            cmd.target = 1'b1;
            state_in   = ST_ERROR;
         end
         ST_ERROR: begin
            cmd.error = 1'b1;
            state_in  = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.integ_mul = 1'b1;
            state_in      = ST_DERIV;
         end
         ST_DERIV: begin
            cmd.deriv_mul = 1'b1;
            state_in      = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = ST_LOW;
         end
         ST_LOW: begin
            cmd.low_mul = 1'b1;
            state_in    = ST_HIGH;
         end
         ST_HIGH: begin
            cmd.high_mul = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/itp_datapath.sv -----
// Datapath: post-start schedule, target selection and PID around one shared multiplier.
module itp_datapath
   import itp_pkg::*;
#(
   parameter int SUM_WIDTH = 24
)
(
   input  logic               clock,
   input  logic               reset,
   input  itp_cmd_type        cmd,
   input  itp_cfg_type        cfg,
   input  logic [9:0]         in_throttle_position,
   input  logic signed [11:0] in_engine_temp,
   input  logic [13:0]        in_engine_rpm,
   input  logic signed [10:0] in_target_adjust,
   output logic signed [11:0] out_target_throttle,
   output logic signed [23:0] out_actuator_demand
);

   localparam int MUL_A_W = (SUM_WIDTH > LO_W + 1) ? SUM_WIDTH : LO_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int INNER_W = SUM_WIDTH + 12;
   localparam int FIN_W   = INNER_W + MUL_B_W;
   localparam int SH_W    = FIN_W - 16;

   // Input word registers.
   logic [9:0]         tps_ff;
   logic signed [11:0] temp_ff;
   logic [13:0]        rpm_ff;
   logic signed [10:0] adj_ff;

   // Controller state carried between words.
   logic [17:0]                 level_ff;
   logic [17:0]                 level_in;
   logic signed [SUM_WIDTH-1:0] sum_ff;
   logic signed [SUM_WIDTH-1:0] sum_in;
   logic signed [12:0]          prev_ff;

   // Working registers of one word.
   logic signed [PROD_W-1:0]  prod_ff;
   logic [9:0]                slope_ff;
   logic [9:0]                slope_in;
   logic signed [11:0]        target_ff;
   logic signed [11:0]        target_in;
   logic signed [12:0]        err_ff;
   logic signed [13:0]        diff_ff;
   logic signed [INNER_W-1:0] acc_ff;
   logic signed [INNER_W-1:0] acc_in;
   logic [LOWP_W-1:0]         lowp_ff;
   logic signed [11:0]        rsp_target_ff;
   logic signed [23:0]        rsp_demand_ff;
   logic signed [23:0]        demand_in;

   // Combinational intermediates.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [20:0]        slope_raw;
   logic signed [11:0]        adj_sum;
   logic signed [11:0]        psl;
   logic signed [12:0]        err;
   logic signed [13:0]        diff;
   logic signed [SUM_WIDTH:0] sum_wide;
   logic signed [FIN_W-1:0]   total;
   logic signed [SH_W-1:0]    scaled;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.slope_mul) begin
         mul_a = MUL_A_W'(temp_ff);
         mul_b = MUL_B_W'(cfg.slope_gradient);
      end else if (cmd.integ_mul) begin
         mul_a = MUL_A_W'(sum_ff);
         mul_b = MUL_B_W'({1'b0, INTEGRAL_GAIN_Q8});
      end else if (cmd.deriv_mul) begin
         mul_a = MUL_A_W'(diff_ff);
         mul_b = MUL_B_W'({1'b0, DERIVATIVE_GAIN_Q8});
      end else if (cmd.low_mul) begin
         mul_a = MUL_A_W'({1'b0, acc_ff[LO_W-1:0]});
         mul_b = MUL_B_W'({1'b0, cfg.loop_gain});
      end else if (cmd.high_mul) begin
         mul_a = MUL_A_W'($signed(acc_ff[INNER_W-1:LO_W]));
         mul_b = MUL_B_W'({1'b0, cfg.loop_gain});
      end
   end

   assign prod_in = mul_a * mul_b;

   // Post-start level: load while cranking, otherwise decay towards zero.
   always_comb begin
      if (rpm_ff > cfg.cranking_rpm) begin
         if (level_ff > 18'(cfg.post_start_step)) begin
            level_in = level_ff - 18'(cfg.post_start_step);
         end else begin
            level_in = '0;
         end
      end else begin
         level_in = {cfg.post_start_start, 8'd0};
      end
   end

   // Temperature slope, floored by the Q8 shift, then clamped to the idle band.
   assign slope_raw = 21'($signed(prod_ff[27:8])) + 21'(cfg.slope_offset);

   always_comb begin
      if (slope_raw < $signed({11'd0, cfg.idle_normal})) begin
         slope_in = cfg.idle_normal;
      end else if (slope_raw > $signed({11'd0, cfg.idle_fast})) begin
         slope_in = cfg.idle_fast;
      end else begin
         slope_in = slope_raw[9:0];
      end
   end

   // Target: trimmed slope, raised to the post-start level when that is higher.
   assign adj_sum = $signed({2'b00, slope_ff}) + 12'(adj_ff);
   assign psl     = $signed({2'b00, level_ff[17:8]});
   assign target_in = (psl > adj_sum) ? psl : adj_sum;

   // Error, saturating integral and difference.
   assign err      = 13'(target_ff) - $signed({3'b000, tps_ff});
   assign diff     = 14'(err) - 14'(prev_ff);
   assign sum_wide = (SUM_WIDTH + 1)'(sum_ff) + (SUM_WIDTH + 1)'(err);

   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_in = {sum_wide[SUM_WIDTH], {(SUM_WIDTH - 1){!sum_wide[SUM_WIDTH]}}};
      end else begin
         sum_in = sum_wide[SUM_WIDTH-1:0];
      end
   end

   // PID sum accumulator.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.integ_mul) begin
         acc_in = INNER_W'(err_ff) <<< 8;
      end else if (cmd.deriv_mul || cmd.accum) begin
         acc_in = acc_ff + INNER_W'(prod_ff);
      end
   end

   // Gain-scaled demand: high partial product shifted up plus the low one,
   // floored by the Q8.8 shift and saturated to 24 bits.
   assign total  = (FIN_W'(prod_ff) <<< LO_W) + FIN_W'({1'b0, lowp_ff});
   assign scaled = total[FIN_W-1:16];

   always_comb begin
      if ((&scaled[SH_W-1:23]) || !(|scaled[SH_W-1:23])) begin
         demand_in = scaled[23:0];
      end else begin
         demand_in = {scaled[SH_W-1], {23{!scaled[SH_W-1]}}};
      end
   end

   // State kept from word to word.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         sum_ff   <= '0;
         prev_ff  <= '0;
      end else begin
         if (cmd.slope_mul) begin
            level_ff <= level_in;
         end
         if (cmd.error) begin
            sum_ff  <= sum_in;
            prev_ff <= err;
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tps_ff  <= in_throttle_position;
         temp_ff <= in_engine_temp;
         rpm_ff  <= in_engine_rpm;
         adj_ff  <= in_target_adjust;
      end
      if (cmd.slope_mul || cmd.integ_mul || cmd.deriv_mul || cmd.low_mul || cmd.high_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.clamp) begin
         slope_ff <= slope_in;
      end
      if (cmd.target) begin
         target_ff <= target_in;
      end
      if (cmd.error) begin
         err_ff  <= err;
         diff_ff <= diff;
      end
      acc_ff <= acc_in;
      if (cmd.high_mul) begin
         lowp_ff <= prod_ff[LOWP_W-1:0];
      end
      if (cmd.finish) begin
         rsp_target_ff <= target_ff;
         rsp_demand_ff <= demand_in;
      end
   end

   assign out_target_throttle = rsp_target_ff;
   assign out_actuator_demand = rsp_demand_ff;

endmodule

// ----- rtl/itp_checker.sv -----
// Port-level assertions for the idle throttle block, bound to its top level.
module itp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [11:0] rsp_target,
   input logic signed [23:0] rsp_demand
);

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target) && $stable(rsp_demand))
      else $error("stalled result changed");

   // One word at a time: the block is busy after taking a word.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // A new result appears as the sequencer returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while busy");

   // The target always lies in its documented range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_target >= -12'sd1024) && (rsp_target <= 12'sd2046))
      else $error("target throttle out of range");

endmodule

bind idle_throttle_target_and_pid itp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_target (rsp_chan.target_throttle),
   .rsp_demand (rsp_chan.actuator_demand)
);

// ----- sim/itp_pid_checker.sv -----
// Checker that predicts every result word of the idle throttle block and compares it.
module itp_pid_checker
   import itp_pkg::*;
#(
   parameter int SUM_WIDTH = 24
)
(
   input  logic        clock,
   input  logic        reset,
   itp_req_if          req_mon,
   itp_rsp_if          rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Fixed PID gains of the block, unsigned Q2.8.
   localparam longint INTEG_GAIN = 26;
   localparam longint DERIV_GAIN = 64;

   typedef struct packed {
      logic signed [11:0] target_throttle;
      logic signed [23:0] actuator_demand;
   } tick_result_type;

   // Mirror of the configuration and of the control state.
   itp_cfg_type     cfg;
   logic [17:0]     post_start_level;
   longint          error_sum;
   longint          previous_error;
   int              fail_total;
   tick_result_type predicted_ticks[$];

   // One control tick: post-start schedule, clamped slope target, then the PID stage.
   function automatic tick_result_type predict_idle_tick(logic [9:0] tps,
                                                         logic signed [11:0] temp,
                                                         logic [13:0] rpm,
                                                         logic signed [10:0] adj);
      longint          slope;
      longint          target;
      longint          err;
      longint          diff;
      longint          inner;
      longint          demand;
      longint          sum_max;
      longint          sum_min;
      tick_result_type res;
      sum_max = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
      sum_min = -sum_max - 1;

      // Load the start level while cranking, otherwise decay towards zero.
      if (rpm > cfg.cranking_rpm) begin
         if (post_start_level > 18'(cfg.post_start_step))
            post_start_level = post_start_level - 18'(cfg.post_start_step);
         else
            post_start_level = '0;
      end else begin
         post_start_level = {cfg.post_start_start, 8'd0};
      end

      // Temperature slope, floored, then clamped low bound first.
      slope = ((longint'($signed(cfg.slope_gradient)) * longint'(temp)) >>> 8)
              + longint'($signed(cfg.slope_offset));
      if (slope < longint'(cfg.idle_normal))
         slope = longint'(cfg.idle_normal);
      else if (slope > longint'(cfg.idle_fast))
         slope = longint'(cfg.idle_fast);
      target = slope + longint'(adj);
      if (longint'(post_start_level[17:8]) > target)
         target = longint'(post_start_level[17:8]);

      // PID with a saturating error sum and a saturated demand.
      err       = target - longint'(tps);
      error_sum = error_sum + err;
      if (error_sum > sum_max)
         error_sum = sum_max;
      else if (error_sum < sum_min)
         error_sum = sum_min;
      diff           = err - previous_error;
      previous_error = err;
      inner  = err * 256 + INTEG_GAIN * error_sum + DERIV_GAIN * diff;
      demand = (longint'(cfg.loop_gain) * inner) >>> 16;
      if (demand > 64'sd8388607)
         demand = 64'sd8388607;
      else if (demand < -64'sd8388608)
         demand = -64'sd8388608;

      res.target_throttle = target[11:0];
      res.actuator_demand = demand[23:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      tick_result_type want;
      if (reset) begin
         cfg.cranking_rpm     = 14'd400;
         cfg.post_start_start = '0;
         cfg.post_start_step  = 16'd256;
         cfg.slope_gradient   = '0;
         cfg.slope_offset     = '0;
         cfg.idle_normal      = '0;
         cfg.idle_fast        = '0;
         cfg.loop_gain        = 16'd256;
         post_start_level     = '0;
         error_sum            = 0;
         previous_error       = 0;
         fail_total           = 0;
         predicted_ticks.delete();
      end else begin
         // A result word is compared against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_ticks.size() == 0) begin
               $display("%0t: result word with nothing expected: target %0d, demand %0d",
                        $time, rsp_mon.target_throttle, rsp_mon.actuator_demand);
               fail_total++;
            end else begin
               want = predicted_ticks.pop_front();
               if (rsp_mon.target_throttle !== want.target_throttle) begin
                  $display("%0t: target_throttle expected %0d, got %0d", $time,
                           want.target_throttle, rsp_mon.target_throttle);
                  fail_total++;
               end
               if (rsp_mon.actuator_demand !== want.actuator_demand) begin
                  $display("%0t: actuator_demand expected %0d, got %0d", $time,
                           want.actuator_demand, rsp_mon.actuator_demand);
                  fail_total++;
               end
            end
         end

         // Every accepted input word yields one prediction.
         if (req_mon.valid && req_mon.ready)
            predicted_ticks.push_back(predict_idle_tick(req_mon.throttle_position,
                                                        req_mon.engine_temp,
                                                        req_mon.engine_rpm,
                                                        req_mon.target_adjust));

         // Follow register writes on the configuration port.
         if (psel && penable && pwrite && pready) begin
            case (itp_reg_type'(paddr[4:2]))
               REG_CRANKING_RPM:     cfg.cranking_rpm     = pwdata[13:0];
               REG_POST_START_START: cfg.post_start_start = pwdata[9:0];
               REG_POST_START_STEP:  cfg.post_start_step  = pwdata[15:0];
               REG_SLOPE_GRADIENT:   cfg.slope_gradient   = pwdata[15:0];
               REG_SLOPE_OFFSET:     cfg.slope_offset     = pwdata[15:0];
               REG_IDLE_NORMAL:      cfg.idle_normal      = pwdata[9:0];
               REG_IDLE_FAST:        cfg.idle_fast        = pwdata[9:0];
               REG_LOOP_GAIN:        cfg.loop_gain        = pwdata[15:0];
            endcase
         end
      end
      mismatches  <= fail_total;
      outstanding <= predicted_ticks.size();
   end

endmodule

// ----- sim/testbench.sv -----
// Top of the idle throttle testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import itp_pkg::*;

   localparam int SUM_WIDTH = 24;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   logic        idling;
   int          mismatches;
   int          outstanding;
   int          crank_left;
   itp_cfg_type active;

   itp_req_if req_chan ();
   itp_rsp_if rsp_chan ();

   idle_throttle_target_and_pid #(.SUM_WIDTH(SUM_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   itp_pid_checker #(.SUM_WIDTH(SUM_WIDTH)) demand_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   // The receiver stalls at random while idling is enabled.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= idling ? ($urandom_range(0, 99) >= 21) : 1'b1;
      end
   end

   function automatic itp_cfg_type make_setting(int crank, int start, int step, int grad,
                                                int offs, int normal, int fast, int gain);
      itp_cfg_type s;
      s.cranking_rpm     = crank[13:0];
      s.post_start_start = start[9:0];
      s.post_start_step  = step[15:0];
      s.slope_gradient   = grad[15:0];
      s.slope_offset     = offs[15:0];
      s.idle_normal      = normal[9:0];
      s.idle_fast        = fast[9:0];
      s.loop_gain        = gain[15:0];
      return s;
   endfunction

   // Mostly plausible calibrations, with the occasional wide gradient, step or gain.
   function automatic itp_cfg_type random_setting();
      itp_cfg_type s;
      s.cranking_rpm     = 14'($urandom_range(0, 3000));
      s.post_start_start = 10'($urandom);
      s.post_start_step  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(1, 2048));
      s.slope_gradient   = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 1023) - 512);
      s.slope_offset     = 16'($urandom_range(0, 2000) - 1000);
      s.idle_normal      = 10'($urandom_range(0, 500));
      s.idle_fast        = 10'($urandom);
      s.loop_gain        = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 1024));
      return s;
   endfunction

   // Setup then access phase; psel stays high so writes may follow back to back.
   task automatic csr_write(input itp_reg_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Waits until every result word is back, then writes the whole register set.
   task automatic program_setting(input itp_cfg_type s);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_write(REG_CRANKING_RPM,     {18'd0, s.cranking_rpm});
      csr_write(REG_POST_START_START, {22'd0, s.post_start_start});
      csr_write(REG_POST_START_STEP,  {16'd0, s.post_start_step});
      csr_write(REG_SLOPE_GRADIENT,   {16'd0, s.slope_gradient});
      csr_write(REG_SLOPE_OFFSET,     {16'd0, s.slope_offset});
      csr_write(REG_IDLE_NORMAL,      {22'd0, s.idle_normal});
      csr_write(REG_IDLE_FAST,        {22'd0, s.idle_fast});
      csr_write(REG_LOOP_GAIN,        {16'd0, s.loop_gain});
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      active = s;
   endtask

   // Offers one input word, after a random gap, and returns at its acceptance.
   task automatic send_word(input logic [9:0] tps, input logic signed [11:0] temp,
                            input logic [13:0] rpm, input logic signed [10:0] adj);
      while (idling && $urandom_range(0, 99) < 21) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.throttle_position <= tps;
      req_chan.engine_temp       <= temp;
      req_chan.engine_rpm        <= rpm;
      req_chan.target_adjust     <= adj;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Engine start sequences: a few cranking ticks, then running ticks while the
   // post-start level decays. One word in ten is noise over the whole field range.
   task automatic random_tick();
      logic [9:0]         tps;
      logic signed [11:0] temp;
      logic [13:0]        rpm;
      logic signed [10:0] adj;
      if ($urandom_range(0, 9) == 0) begin
         tps  = 10'($urandom);
         temp = 12'($urandom);
         rpm  = 14'($urandom);
         adj  = 11'($urandom);
      end else begin
         tps  = 10'($urandom_range(0, 1000));
         temp = 12'($urandom_range(0, 1900) - 400);
         adj  = 11'($urandom_range(0, 2000) - 1000);
         if (crank_left > 0) begin
            rpm = 14'($urandom_range(0, active.cranking_rpm));
            crank_left--;
         end else if (active.cranking_rpm == 14'h3FFF) begin
            rpm = 14'($urandom);
         end else if ($urandom_range(0, 19) == 0) begin
            rpm = active.cranking_rpm + 14'd1;
         end else begin
            rpm = 14'($urandom_range(active.cranking_rpm + 1, 16383));
         end
         if (crank_left == 0 && $urandom_range(0, 29) == 0)
            crank_left = $urandom_range(1, 4);
      end
      send_word(tps, temp, rpm, adj);
   endtask

   initial begin : stimulus
      int drain;
      reset                      <= 1'b1;
      idling                     <= 1'b1;
      psel                       <= 1'b0;
      penable                    <= 1'b0;
      pwrite                     <= 1'b0;
      paddr                      <= '0;
      pwdata                     <= '0;
      req_chan.valid             <= 1'b0;
      req_chan.throttle_position <= '0;
      req_chan.engine_temp       <= '0;
      req_chan.engine_rpm        <= '0;
      req_chan.target_adjust     <= '0;
      crank_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Typical calibration: field extremes, the cranking threshold and a
      // decay step large enough to floor the post-start level at zero.
      program_setting(make_setting(400, 300, 30000, -256, 250, 80, 250, 256));
      send_word(10'd0,    -12'sd400,  14'd0,     11'sd0);
      send_word(10'd1000, 12'sd1500,  14'd400,   -11'sd1000);
      send_word(10'd1023, -12'sd2048, 14'd401,   11'sd1023);
      send_word(10'd0,    12'sd2047,  14'd16383, -11'sd1024);
      send_word(10'd512,  12'sd0,     14'd16383, 11'sd1000);
      repeat (3) send_word(10'd100, 12'sd200, 14'd900, 11'sd0);

      // Every register at its top value: the engine never counts as running.
      program_setting(make_setting(16383, 1023, 65535, 32767, 32767, 1023, 1023, 65535));
      send_word(10'd1023, 12'sd2047,  14'd16383, 11'sd1023);
      send_word(10'd0,    -12'sd2048, 14'd0,     -11'sd1024);
      send_word(10'd1000, 12'sd1500,  14'd16382, 11'sd1000);
      repeat (90) random_tick();

      // Every register at its bottom value.
      program_setting(make_setting(0, 0, 0, -32768, -32768, 0, 0, 0));
      send_word(10'd0,    -12'sd400, 14'd1, -11'sd1000);
      send_word(10'd1023, 12'sd1500, 14'd0, 11'sd1023);
      repeat (90) random_tick();

      // Normal idle above fast idle, with the demand driven into saturation.
      program_setting(make_setting(2000, 1000, 512, 256, 0, 900, 100, 65535));
      repeat (90) random_tick();

      // A long stretch without gaps or stalls on either side.
      program_setting(make_setting(400, 300, 256, -256, 250, 80, 250, 256));
      idling <= 1'b0;
      repeat (90) random_tick();
      idling <= 1'b1;

      repeat (2) begin
         program_setting(random_setting());
         repeat (65) random_tick();
      end

      // Build up a large positive error sum with the largest target, then
      // pull it back down with the smallest one.
      program_setting(make_setting(0, 0, 65535, 0, 0, 1023, 1023, 65535));
      idling <= 1'b0;
      repeat (40)
         send_word(10'($urandom_range(0, 15)), 12'($urandom_range(0, 1900) - 400),
                   14'($urandom_range(1, 16383)), 11'sd1023);
      program_setting(make_setting(0, 0, 65535, 0, 0, 0, 0, 1));
      repeat (40)
         send_word(10'($urandom_range(1008, 1023)), 12'($urandom_range(0, 1900) - 400),
                   14'($urandom_range(1, 16383)), -11'sd1024);

      // Drain the outstanding result words, then settle.
      req_chan.valid <= 1'b0;
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (outstanding != 0 && drain < 5000);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/itp_pkg.sv
rtl/itp_if.sv
rtl/itp_csr.sv
rtl/itp_ctrl.sv
rtl/itp_datapath.sv
rtl/idle_throttle_target_and_pid.sv
rtl/itp_checker.sv
sim/itp_pid_checker.sv
sim/testbench.sv
